[rtl/core/pps_pkg.sv]
// pure pursuit steering package: command codes, config register indexes,
// cordic constants and the arctangent table. depends on nothing
package pps_pkg;

  typedef enum logic [1:0] {
    CMD_POINT  = 2'd0,
    CMD_LEFT   = 2'd1,
    CMD_RIGHT  = 2'd2,
    CMD_CENTER = 2'd3
  } cmd_e_t;

  typedef enum logic [1:0] {
    CFG_WHEELBASE = 2'd0,
    CFG_CENTER    = 2'd1,
    CFG_MAX_ANGLE = 2'd2,
    CFG_UNUSED    = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    cmd_e_t cmd;
    logic   xneg;
    logic   skip;
  } side_t;

  localparam int CORDIC_STEPS = 20;
  localparam int NORM_MSB     = 40;   // normalized operands lie in [2^40, 2^41)
  localparam int NORM_W       = 41;
  localparam int CORD_W       = 44;   // cordic x / y datapath
  localparam int ZACC_W       = 25;   // angle accumulator, degrees q16, signed
  localparam int ZMAG_W       = 24;
  localparam int SERVO_MAX    = 180;

  // atan(2^-i) in degrees, 16 fraction bits
  function automatic logic signed [ZACC_W-1:0] atan_q16(input int i);
    logic signed [ZACC_W-1:0] v;
    unique case (i)
      0:       v = 25'sd2949120;
      1:       v = 25'sd1740967;
      2:       v = 25'sd919879;
      3:       v = 25'sd466945;
      4:       v = 25'sd234379;
      5:       v = 25'sd117304;
      6:       v = 25'sd58666;
      7:       v = 25'sd29335;
      8:       v = 25'sd14668;
      9:       v = 25'sd7334;
      10:      v = 25'sd3667;
      11:      v = 25'sd1833;
      12:      v = 25'sd917;
      13:      v = 25'sd458;
      14:      v = 25'sd229;
      15:      v = 25'sd115;
      16:      v = 25'sd57;
      17:      v = 25'sd29;
      18:      v = 25'sd14;
      default: v = 25'sd7;
    endcase
    return v;
  endfunction

endpackage

[rtl/core/pure_pursuit_steering.sv]
// pure pursuit steering top level: lookahead point to servo command,
// fully pipelined cordic arctangent. depends on pps_pkg
//
// usage
//   input beat: start high while busy is low takes in_cmd, in_look_x and
//   in_look_y. busy is always low, so a beat can enter in every cycle.
//   in_cmd selects a lookahead point or a manual left, right or center.
//   result beat: out_valid is high for one cycle with out_servo_position
//   and out_steer_angle; the receiver has no way to stall the block.
//   config: cfg_we writes cfg_wdata into register cfg_addr (0 wheelbase,
//   1 center position, 2 max angle) in the same edge; index 3 is ignored.
//   write config only while no beat is in flight.
// throughput and depth
//   one beat per cycle.
//   the depth is set by the 20 cordic vectoring stages, one
//   micro-rotation per stage, plus stages for the magnitudes, the three
//   multipliers, the leading-one search, the normalizing shift, rounding
//   and the final clamp.
// reset
//   rst_n low empties the pipeline (no result strobes follow) and loads
//   wheelbase 240, center 90 and max angle 30.
module pure_pursuit_steering #(
  parameter int COORD_WIDTH     = 16,
  parameter int ANGLE_FRAC_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_cmd,
  input  logic signed [COORD_WIDTH-1:0] in_look_x,
  input  logic signed [COORD_WIDTH-1:0] in_look_y,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_addr,
  input  logic [11:0]                   cfg_wdata,
  output logic                          out_valid,
  output logic [7:0]                    out_servo_position,
  output logic signed [15:0]            out_steer_angle
);
  import pps_pkg::*;

  localparam int CW  = COORD_WIDTH;
  localparam int NW  = (2 * CW + 1 > CW + 13) ? 2 * CW + 1 : CW + 13;  // n, d width
  localparam int NG  = (NW + 7) / 8;                                   // 8-bit groups
  localparam int PW  = $clog2(NG * 8);                                 // msb index
  localparam int TW  = (NW > NORM_W) ? NW : NORM_W;                    // shifter width
  localparam int RSH = 16 - ANGLE_FRAC_BITS;
  localparam int RND = (RSH > 0) ? (1 << ((RSH > 0) ? RSH - 1 : 0)) : 0;

  // stage numbering: 0 input, 1 products, 2 n and d, 3 group scan,
  // 4 msb pick, 5 normalize, 6..25 cordic, 26 round, 27 output
  localparam int S_CORD0 = 5;
  localparam int S_ROUND = S_CORD0 + CORDIC_STEPS + 1;
  localparam int NST     = S_ROUND + 1;

  // configuration registers
  logic [11:0] wheelbase_r;
  logic [7:0]  center_r;
  logic [6:0]  max_angle_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wheelbase_r <= 12'd240;
      center_r    <= 8'd90;
      max_angle_r <= 7'd30;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_WHEELBASE: wheelbase_r <= cfg_wdata;
        CFG_CENTER:    center_r    <= cfg_wdata[7:0];
        CFG_MAX_ANGLE: max_angle_r <= cfg_wdata[6:0];
        CFG_UNUSED:    ;
      endcase
    end
  end

  assign busy = 1'b0;

  // valid bits and sideband travel the whole pipe
  logic  valid_r [NST];
  side_t side_r  [NST];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NST; k++) valid_r[k] <= 1'b0;
    end else begin
      valid_r[0] <= start;
      for (int k = 1; k < NST; k++) valid_r[k] <= valid_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    side_r[0].cmd  <= cmd_e_t'(in_cmd);
    side_r[0].xneg <= in_look_x[CW-1];
    side_r[0].skip <= (in_look_x == '0) || (wheelbase_r == '0);
    for (int k = 1; k < NST; k++) side_r[k] <= side_r[k-1];
  end

  // stage 0: coordinate magnitudes
  logic [CW-1:0] ax_r, ay_r;

  always_ff @(posedge clk) begin
    ax_r <= in_look_x[CW-1] ? CW'(-in_look_x) : CW'(in_look_x);
    ay_r <= in_look_y[CW-1] ? CW'(-in_look_y) : CW'(in_look_y);
  end

  // stage 1: products
  logic [2*CW-1:0] sqx_r, sqy_r;
  logic [CW+11:0]  axwb_r;

  always_ff @(posedge clk) begin
    sqx_r  <= (2*CW)'(ax_r) * (2*CW)'(ax_r);
    sqy_r  <= (2*CW)'(ay_r) * (2*CW)'(ay_r);
    axwb_r <= (CW+12)'(ax_r) * (CW+12)'(wheelbase_r);
  end

  // stage 2: numerator n = 2*|x|*wb, denominator d = x^2 + y^2
  logic [NW-1:0] n_r [3], d_r [3];

  always_ff @(posedge clk) begin
    n_r[0] <= NW'({axwb_r, 1'b0});
    d_r[0] <= NW'(sqx_r) + NW'(sqy_r);
    n_r[1] <= n_r[0];
    d_r[1] <= d_r[0];
    n_r[2] <= n_r[1];
    d_r[2] <= d_r[1];
  end

  // stage 3: per-group leading one of n | d
  logic [NG*8-1:0] scan_w;
  logic            grp_hit_nxt [NG];
  logic [2:0]      grp_pos_nxt [NG];
  logic            grp_hit_r   [NG];
  logic [2:0]      grp_pos_r   [NG];

  assign scan_w = (NG*8)'(n_r[0] | d_r[0]);

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_hit_nxt[g] = 1'b0;
      grp_pos_nxt[g] = 3'd0;
      for (int b = 0; b < 8; b++) begin
        if (scan_w[g*8+b]) begin
          grp_hit_nxt[g] = 1'b1;
          grp_pos_nxt[g] = 3'(b);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < NG; g++) begin
      grp_hit_r[g] <= grp_hit_nxt[g];
      grp_pos_r[g] <= grp_pos_nxt[g];
    end
  end

  // stage 4: pick highest nonzero group
  logic [PW-1:0] msb_nxt, msb_r;

  always_comb begin
    msb_nxt = '0;
    for (int g = 0; g < NG; g++) begin
      if (grp_hit_r[g]) msb_nxt = (PW'(g) << 3) | PW'(grp_pos_r[g]);
    end
  end

  always_ff @(posedge clk) msb_r <= msb_nxt;

  // stage 5: shift n and d together so the larger has its msb at bit 40
  logic [6:0]  msb7_w, shamt_w;
  logic        shr_w;
  logic [TW-1:0] nsh_w, dsh_w;

  assign msb7_w  = 7'(msb_r);
  assign shr_w   = msb7_w >= 7'(NORM_MSB);
  assign shamt_w = shr_w ? msb7_w - 7'(NORM_MSB) : 7'(NORM_MSB) - msb7_w;
  assign nsh_w   = shr_w ? TW'(n_r[2]) >> shamt_w : TW'(n_r[2]) << shamt_w;
  assign dsh_w   = shr_w ? TW'(d_r[2]) >> shamt_w : TW'(d_r[2]) << shamt_w;

  // cordic vectoring: x starts at d, y at n
  logic signed [CORD_W-1:0] cx_r [CORDIC_STEPS+1];
  logic signed [CORD_W-1:0] cy_r [CORDIC_STEPS+1];
  logic signed [ZACC_W-1:0] cz_r [CORDIC_STEPS+1];

  always_ff @(posedge clk) begin
    cx_r[0] <= CORD_W'(dsh_w[NORM_W-1:0]);
    cy_r[0] <= CORD_W'(nsh_w[NORM_W-1:0]);
    cz_r[0] <= '0;
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (cy_r[i] > 0) begin
        cx_r[i+1] <= cx_r[i] + (cy_r[i] >>> i);
        cy_r[i+1] <= cy_r[i] - (cx_r[i] >>> i);
        cz_r[i+1] <= cz_r[i] + atan_q16(i);
      end else begin
        cx_r[i+1] <= cx_r[i] - (cy_r[i] >>> i);
        cy_r[i+1] <= cy_r[i] + (cx_r[i] >>> i);
        cz_r[i+1] <= cz_r[i] - atan_q16(i);
      end
    end
  end

  // round stage: raise negatives to zero, round half up to output fraction, zero unless an unskipped point
  logic [ZMAG_W-1:0] zpos_w, zmag_r;
  logic [ZMAG_W-1:0] zrnd_w;
  logic              point_w;

  assign zpos_w  = cz_r[CORDIC_STEPS][ZACC_W-1] ? '0 : cz_r[CORDIC_STEPS][ZMAG_W-1:0];
  assign zrnd_w  = (zpos_w + ZMAG_W'(RND)) >> RSH;
  assign point_w = side_r[S_ROUND-1].cmd == CMD_POINT && !side_r[S_ROUND-1].skip;

  always_ff @(posedge clk) zmag_r <= point_w ? zrnd_w : '0;

  // output stage: signed unclamped angle, clamp for the servo, whole degrees, servo saturation
  logic [ZMAG_W-1:0]        limit_w, clmag_w;
  logic [6:0]               whole_w;
  logic signed [9:0]        servo_sum_w;
  logic signed [ZMAG_W:0]   angle_w;
  logic [7:0]               servo_w;
  side_t                    so_w;

  assign so_w    = side_r[S_ROUND];
  assign limit_w = ZMAG_W'(max_angle_r) << ANGLE_FRAC_BITS;
  assign clmag_w = (zmag_r > limit_w) ? limit_w : zmag_r;
  assign whole_w = 7'(clmag_w >> ANGLE_FRAC_BITS);
  assign angle_w = so_w.xneg ? -$signed({1'b0, zmag_r}) : $signed({1'b0, zmag_r});

  always_comb begin
    unique case (so_w.cmd)
      CMD_LEFT:   servo_sum_w = $signed({2'b00, center_r}) - $signed({3'b000, max_angle_r});
      CMD_RIGHT:  servo_sum_w = $signed({2'b00, center_r}) + $signed({3'b000, max_angle_r});
      CMD_CENTER: servo_sum_w = $signed({2'b00, center_r});
      default: begin
        if (so_w.xneg) servo_sum_w = $signed({2'b00, center_r}) - $signed({3'b000, whole_w});
        else           servo_sum_w = $signed({2'b00, center_r}) + $signed({3'b000, whole_w});
      end
    endcase
    if (servo_sum_w < 0)                       servo_w = 8'd0;
    else if (servo_sum_w > 10'sd180)           servo_w = 8'(SERVO_MAX);
    else                                       servo_w = servo_sum_w[7:0];
  end

  logic              out_valid_r;
  logic [7:0]        out_servo_r;
  logic signed [15:0] out_steer_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= valid_r[S_ROUND];
  end

  always_ff @(posedge clk) begin
    out_servo_r <= servo_w;
    out_steer_r <= angle_w[15:0];
  end

  assign out_valid          = out_valid_r;
  assign out_servo_position = out_servo_r;
  assign out_steer_angle    = out_steer_r;

endmodule

[verif/pure_pursuit_steering_tb.sv]
// testbench for pure_pursuit_steering: self-checking, with a per-beat steering predictor.
// depends on pps_pkg and the pure_pursuit_steering rtl
`timescale 1ns / 1ps

module pure_pursuit_steering_tb;
  import pps_pkg::*;

  typedef struct {
    cmd_e_t             cmd;
    logic signed [15:0] x;
    logic signed [15:0] y;
  } look_beat_t;

  typedef struct {
    logic [7:0]         servo;
    logic signed [15:0] angle;
  } steer_t;

  // atan(2^-i) in degrees, q16
  localparam longint ATAN_DEG [20] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7
  };
  localparam int PIPE_DRAIN = 40;
  localparam int IDLE_LIMIT = 5000;   // cycles with no beat on either side

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [1:0]         in_cmd;
  logic signed [15:0] in_look_x;
  logic signed [15:0] in_look_y;
  logic               cfg_we;
  logic [1:0]         cfg_addr;
  logic [11:0]        cfg_wdata;
  logic               out_valid;
  logic [7:0]         out_servo_position;
  logic signed [15:0] out_steer_angle;

  // predictor's copy of the registers
  logic [11:0] wheelbase_q;
  logic [7:0]  center_q;
  logic [6:0]  max_angle_q;

  look_beat_t pending_points[$];
  steer_t     expected_steer[$];
  int         sent_beats;
  int         checked_beats;
  int         mismatches;
  int         idle_cycles;
  int         burst_left;
  int         gap_left;
  int         cfg_writes;

  pure_pursuit_steering DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_cmd             (in_cmd),
    .in_look_x          (in_look_x),
    .in_look_y          (in_look_y),
    .cfg_we             (cfg_we),
    .cfg_addr           (cfg_addr),
    .cfg_wdata          (cfg_wdata),
    .out_valid          (out_valid),
    .out_servo_position (out_servo_position),
    .out_steer_angle    (out_steer_angle)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // servo position saturates to the mechanical range
  function automatic longint servo_sat(longint v);
    if (v < 0) return 0;
    if (v > 180) return 180;
    return v;
  endfunction

  // expected servo command and unclamped angle for one beat
  function automatic steer_t steer_predict(look_beat_t b);
    longint ax, ay, n, d, xv, yv, xs, ys, z, ang, lim, clp, whole, servo;
    steer_t r;
    ang = 0;
    case (b.cmd)
      CMD_LEFT:   servo = servo_sat(longint'(center_q) - longint'(max_angle_q));
      CMD_RIGHT:  servo = servo_sat(longint'(center_q) + longint'(max_angle_q));
      CMD_CENTER: servo = servo_sat(longint'(center_q));
      default: begin
        ax = (b.x < 0) ? -longint'(b.x) : longint'(b.x);
        ay = (b.y < 0) ? -longint'(b.y) : longint'(b.y);
        // zero lateral offset or zero wheelbase means straight ahead
        if (ax != 0 && wheelbase_q != 0) begin
          n = 2 * ax * longint'(wheelbase_q);
          d = ax * ax + ay * ay;
          // bring the larger operand into [2^40, 2^41)
          while ((n > d ? n : d) >= (longint'(1) << 41)) begin
            n = n >> 1;
            d = d >> 1;
          end
          while ((n > d ? n : d) < (longint'(1) << 40)) begin
            n = n << 1;
            d = d << 1;
          end
          xv = d;
          yv = n;
          z  = 0;
          // vectoring, arithmetic shifts floor negative values
          for (int i = 0; i < 20; i++) begin
            xs = xv >>> i;
            ys = yv >>> i;
            if (yv > 0) begin
              xv = xv + ys;
              yv = yv - xs;
              z  = z + ATAN_DEG[i];
            end else begin
              xv = xv - ys;
              yv = yv + xs;
              z  = z - ATAN_DEG[i];
            end
          end
          if (z < 0) z = 0;
          z   = (z + 128) >>> 8;
          ang = (b.x < 0) ? -z : z;
        end
        lim = longint'(max_angle_q) << 8;
        clp = ang;
        if (clp > lim) clp = lim;
        if (clp < -lim) clp = -lim;
        whole = (clp < 0) ? -((-clp) >>> 8) : (clp >>> 8);
        servo = servo_sat(longint'(center_q) + whole);
      end
    endcase
    r.servo = servo[7:0];
    r.angle = ang[15:0];
    return r;
  endfunction

  // driver: bursts of beats from the pending queue, random gaps between
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        look_beat_t acc;
        acc.cmd = cmd_e_t'(in_cmd);
        acc.x   = in_look_x;
        acc.y   = in_look_y;
        expected_steer.push_back(steer_predict(acc));
        sent_beats++;
      end
      if (start && busy) begin
        // hold the beat until it is taken
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_points.size() > 0) begin
        look_beat_t nxt;
        nxt = pending_points.pop_front();
        in_cmd    <= nxt.cmd;
        in_look_x <= nxt.x;
        in_look_y <= nxt.y;
        start     <= 1'b1;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          // a quarter of the bursts run back to back
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          burst_left = $urandom_range(1, 30);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: results cannot be stalled, check each strobe against the oldest prediction
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid || (start && !busy)) idle_cycles = 0;
      else idle_cycles++;
      if (out_valid) begin
        if (expected_steer.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result beat: servo %0d angle %0d",
                     out_servo_position, out_steer_angle);
        end else begin
          steer_t e;
          e = expected_steer.pop_front();
          checked_beats++;
          if (e.servo !== out_servo_position || e.angle !== out_steer_angle) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch on result %0d: servo exp %0d got %0d, angle exp %0d got %0d",
                       checked_beats, e.servo, out_servo_position, e.angle,
                       out_steer_angle);
          end
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no beat moved for %0d cycles", IDLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic add_point(cmd_e_t c, int x, int y);
    look_beat_t b;
    b.cmd = c;
    b.x   = x[15:0];
    b.y   = y[15:0];
    pending_points.push_back(b);
  endtask

  // wait until everything sent has come back, then for the pipe to empty
  task automatic drain_pipe();
    while (pending_points.size() > 0 || start || expected_steer.size() > 0)
      @(posedge clk);
    repeat (PIPE_DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [11:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= v;
    case (idx)
      CFG_WHEELBASE: wheelbase_q = v;
      CFG_CENTER:    center_q    = v[7:0];
      CFG_MAX_ANGLE: max_angle_q = v[6:0];
      default: ;
    endcase
    cfg_writes++;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_regs(int wb, int ctr, int mx);
    write_reg(CFG_WHEELBASE, wb[11:0]);
    write_reg(CFG_CENTER, ctr[11:0]);
    write_reg(CFG_MAX_ANGLE, mx[11:0]);
  endtask

  // random beats: mostly points, coordinates from full range or near the car
  task automatic add_random(int count);
    int sel;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 9);
      if (sel < 3) begin
        add_point(cmd_e_t'($urandom_range(1, 3)), $urandom, $urandom);
      end else if (sel < 6) begin
        add_point(CMD_POINT, $urandom, $urandom);
      end else begin
        add_point(CMD_POINT, $urandom_range(0, 1600) - 800, $urandom_range(0, 1600) - 800);
      end
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    start         = 1'b0;
    in_cmd        = CMD_POINT;
    in_look_x     = '0;
    in_look_y     = '0;
    cfg_we        = 1'b0;
    cfg_addr      = CFG_WHEELBASE;
    cfg_wdata     = '0;
    wheelbase_q   = 12'd240;
    center_q      = 8'd90;
    max_angle_q   = 7'd30;
    sent_beats    = 0;
    checked_beats = 0;
    mismatches    = 0;
    idle_cycles   = 0;
    burst_left    = $urandom_range(1, 30);
    gap_left      = 0;
    cfg_writes    = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed beats on reset settings: origin, axis points, field extremes, manual moves
    add_point(CMD_POINT, 0, 0);
    add_point(CMD_POINT, 0, -32768);
    add_point(CMD_POINT, 0, 32767);
    add_point(CMD_POINT, 1, 0);
    add_point(CMD_POINT, -1, 0);
    add_point(CMD_POINT, 32767, 0);
    add_point(CMD_POINT, -32768, -32768);
    add_point(CMD_POINT, 32767, 32767);
    add_point(CMD_POINT, 1, 32767);
    add_point(CMD_POINT, -1, -32768);
    add_point(CMD_POINT, 240, 480);
    add_point(CMD_POINT, -160, 320);
    add_point(CMD_LEFT, 123, -456);
    add_point(CMD_RIGHT, -1, 1);
    add_point(CMD_CENTER, -32768, 32767);
    add_random(150);
    // sender holds off here until every result is back
    drain_pipe();

    // widest settings, center at the top of the servo range
    set_regs(4095, 180, 90);
    add_point(CMD_POINT, 1, 0);
    add_point(CMD_POINT, -1, 0);
    add_point(CMD_POINT, 100, 32767);
    add_point(CMD_LEFT, 0, 0);
    add_point(CMD_RIGHT, 0, 0);
    add_random(250);
    drain_pipe();

    // zero everything: no wheelbase, no deflection
    set_regs(0, 0, 0);
    add_point(CMD_POINT, 500, 10);
    add_point(CMD_LEFT, 0, 0);
    add_random(150);
    drain_pipe();

    // registers above their useful range, unused index is ignored
    set_regs(12'hfff, 255, 127);
    write_reg(CFG_UNUSED, 12'h5a5);
    add_point(CMD_LEFT, 0, 0);
    add_point(CMD_RIGHT, 0, 0);
    add_point(CMD_CENTER, 0, 0);
    add_point(CMD_POINT, -3, 2);
    add_random(200);
    drain_pipe();

    // several random settings
    for (int p = 0; p < 4; p++) begin
      set_regs($urandom_range(0, 4095), $urandom_range(0, 180), $urandom_range(0, 90));
      add_random(120);
      drain_pipe();
    end

    $display("sent %0d beats, checked %0d results over %0d register writes",
             sent_beats, checked_beats, cfg_writes);
    $display("covered points, manual moves, zero and extreme coordinates and settings; %0d mismatches",
             mismatches);
    if (mismatches == 0 && expected_steer.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
